// File: sv/tcpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcpg_pkg
// shared types, rule tables and helpers of the triangle cubature generator
// ---------------------------------------------------------------------------
package tcpg_pkg;

    localparam int NUM_GENS  = 51;
    localparam int NUM_RULES = 14;
    localparam logic [1:0] CFG_DEGREE = 2'd0;
    localparam logic [1:0] CFG_RULE   = 2'd1;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam longint unsigned THIRD = 64'd333333333333333330;

    typedef struct packed {
        logic       start;
        logic       advance;
        logic [3:0] rule;
    } t_seq_ctl;

    // fraction scaled by 1e18 to Q2.30, rounded to nearest
    function automatic logic [31:0] q30(input longint unsigned m);
        longint unsigned fa;
        longint unsigned fb;
        longint unsigned hi;
        fa = m / 64'd1000000000;
        fb = m % 64'd1000000000;
        hi = fa * 64'd1073741824;
        return 32'(hi / 64'd1000000000
            + ((hi % 64'd1000000000) * 64'd1000000000 + fb * 64'd1073741824
               + 64'd500000000000000000) / 64'd1000000000000000000);
    endfunction

    localparam logic [2:0] GEN_KIND [NUM_GENS] = '{
        3'd1, 3'd3, 3'd1, 3'd3, 3'd6, 3'd3, 3'd3, 3'd1, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd6, 3'd3, 3'd3, 3'd6, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd1, 3'd3, 3'd3, 3'd3, 3'd6, 3'd1, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd6, 3'd1, 3'd3, 3'd3, 3'd6, 3'd6, 3'd6, 3'd1, 3'd3, 3'd3,
        3'd6, 3'd6, 3'd6, 3'd6, 3'd1, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd6};

    localparam logic [31:0] GEN_C1 [NUM_GENS] = '{
        q30(THIRD), q30(64'd166666666666666660), q30(THIRD),
        q30(64'd200000000000000000), q30(64'd109039009072877210),
        q30(64'd91576213509770743), q30(64'd445948490915964880), q30(THIRD),
        q30(64'd101286507323456330), q30(64'd470142064105115080),
        q30(64'd63089014491502228), q30(64'd249286745170910420),
        q30(64'd53145049844816947), q30(64'd219429982549782960),
        q30(64'd480137964112215040), q30(64'd839009259714791050),
        q30(64'd62382265094402118), q30(64'd55225456656926611),
        q30(64'd34324302945097146), q30(64'd515842334353591770), q30(THIRD),
        q30(64'd170569307751760200), q30(64'd50547228317030975),
        q30(64'd459292588292723150), q30(64'd728492392955404280), q30(THIRD),
        q30(64'd489682519198737620), q30(64'd437089591492936630),
        q30(64'd188203535619032730), q30(64'd44729513394452709),
        q30(64'd741198598784498020), q30(THIRD), q30(64'd425086210602090570),
        q30(64'd23308867510000190), q30(64'd628307400213492550),
        q30(64'd611313826181397640), q30(64'd821072069985629370), q30(THIRD),
        q30(64'd142161101056564380), q30(64'd32055373216943512),
        q30(64'd530054118927344020), q30(64'd601233328683459240),
        q30(64'd807930600922879060), q30(64'd858870281282636700), q30(THIRD),
        q30(64'd25989140928287395), q30(64'd94287502647922495),
        q30(64'd494636775017213810), q30(64'd207343382614511330),
        q30(64'd438907805700492090), q30(64'd677937654882590400)};

    localparam logic [31:0] GEN_C2 [NUM_GENS] = '{
        q30(THIRD), q30(64'd166666666666666660), q30(THIRD),
        q30(64'd200000000000000000), q30(64'd231933368553030570),
        q30(64'd91576213509770743), q30(64'd445948490915964880), q30(THIRD),
        q30(64'd101286507323456330), q30(64'd470142064105115080),
        q30(64'd63089014491502228), q30(64'd249286745170910420),
        q30(64'd310352451033784400), q30(64'd219429982549782960),
        q30(64'd480137964112215040), q30(64'd141619015923968150),
        q30(64'd67517867073916085), q30(64'd321502493851981820),
        q30(64'd660949196186735650), q30(64'd277716166976391780), q30(THIRD),
        q30(64'd170569307751760200), q30(64'd50547228317030975),
        q30(64'd459292588292723150), q30(64'd263112829634638110), q30(THIRD),
        q30(64'd489682519198737620), q30(64'd437089591492936630),
        q30(64'd188203535619032730), q30(64'd44729513394452709),
        q30(64'd36838412054736283), q30(THIRD), q30(64'd425086210602090570),
        q30(64'd23308867510000190), q30(64'd223766973576973000),
        q30(64'd358740141864431460), q30(64'd143295370426867140), q30(THIRD),
        q30(64'd142161101056564380), q30(64'd32055373216943512),
        q30(64'd321812995288835420), q30(64'd369146781827810980),
        q30(64'd163701733737182490), q30(64'd141129718717363290), q30(THIRD),
        q30(64'd25989140928287395), q30(64'd94287502647922495),
        q30(64'd494636775017213810), q30(64'd207343382614511330),
        q30(64'd438907805700492090), q30(64'd44841677589130443)};

    localparam logic [31:0] GEN_W [NUM_GENS] = '{
        q30(64'd500000000000000000), q30(64'd166666666666666660),
        32'(-q30(64'd281250000000000000)), q30(64'd260416666666666670),
        q30(64'd83333333333333333), q30(64'd54975871827660933),
        q30(64'd111690794839005730), q30(64'd112500000000000000),
        q30(64'd62969590272413576), q30(64'd66197076394253090),
        q30(64'd25422453185103408), q30(64'd58393137863189683),
        q30(64'd41425537809186787), q30(64'd85666562076490515),
        q30(64'd40365544796515489), q30(64'd20317279896830331),
        q30(64'd26517028157436251), q30(64'd43881408714446055),
        q30(64'd28775042784981585), q30(64'd67493187009802774),
        q30(64'd72157803838893584), q30(64'd51608685267359125),
        q30(64'd16229248811599040), q30(64'd47545817133642312),
        q30(64'd13615157087217497), q30(64'd48567898141399416),
        q30(64'd15667350113569535), q30(64'd38913770502387139),
        q30(64'd39823869463605126), q30(64'd12788837829349015),
        q30(64'd21641769688644688), q30(64'd39947252370619853),
        q30(64'd35561901116188667), q30(64'd4111909345232098),
        q30(64'd22715296148085009), q30(64'd18679928117152638),
        q30(64'd15443328442281994), q30(64'd40871664573142983),
        q30(64'd22978981802372364), q30(64'd6676484406574783),
        q30(64'd31952453198212022), q30(64'd17092324081479714),
        q30(64'd12648878853644192), q30(64'd3681191891650277),
        q30(64'd43988650581116119), q30(64'd4372155776868012),
        q30(64'd19040785996967468), q30(64'd9427724028065646),
        q30(64'd36079848772369763), q30(64'd34664569352767949),
        q30(64'd20528157714644283)};

    localparam logic [5:0] RULE_FIRST [NUM_RULES] = '{
        6'd0, 6'd1, 6'd2, 6'd4, 6'd5, 6'd7, 6'd10, 6'd13, 6'd16, 6'd20,
        6'd25, 6'd31, 6'd37, 6'd43};

    localparam logic [4:0] RULE_POINTS [NUM_RULES] = '{
        5'd1, 5'd3, 5'd4, 5'd6, 5'd6, 5'd7, 5'd12, 5'd12, 5'd12, 5'd16,
        5'd19, 5'd25, 5'd25, 5'd28};

    function automatic logic [3:0] pick_rule(input logic [3:0] d, input logic [1:0] r);
        logic [5:0] key;
        key = {d, r};
        unique case (key)
            {4'd1, 2'd1}:  return 4'd0;
            {4'd2, 2'd1}:  return 4'd1;
            {4'd3, 2'd1}:  return 4'd2;
            {4'd3, 2'd2}:  return 4'd3;
            {4'd4, 2'd1}:  return 4'd4;
            {4'd5, 2'd1}:  return 4'd5;
            {4'd6, 2'd1}:  return 4'd6;
            {4'd6, 2'd2}:  return 4'd7;
            {4'd7, 2'd1}:  return 4'd8;
            {4'd8, 2'd1}:  return 4'd9;
            {4'd9, 2'd1}:  return 4'd10;
            {4'd10, 2'd1}: return 4'd11;
            {4'd10, 2'd2}: return 4'd12;
            default:       return 4'd13;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: sv/triangle_cubature_point_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// triangle_cubature_point_generator
// emits the symmetric cubature points of a triangle, one transaction each
// points: each point is computed in the calc state, then held in the out state
//   until taken; a new triangle is accepted only in idle, after the last point
//   (the single shared multiplier forms each point as 4 sums x 5 steps)
// reset: synchronous active low; degree 11 rule 1 selected, block idle
// ---------------------------------------------------------------------------
module triangle_cubature_point_generator import tcpg_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write port
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [3:0]         i_cfg_data,
    // triangle input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_vertex_a_x,
    input  wire logic signed [31:0] i_vertex_a_y,
    input  wire logic signed [31:0] i_vertex_a_z,
    input  wire logic signed [31:0] i_vertex_b_x,
    input  wire logic signed [31:0] i_vertex_b_y,
    input  wire logic signed [31:0] i_vertex_b_z,
    input  wire logic signed [31:0] i_vertex_c_x,
    input  wire logic signed [31:0] i_vertex_c_y,
    input  wire logic signed [31:0] i_vertex_c_z,
    input  wire logic [31:0]        i_triangle_area,
    // point output channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_point_x,
    output logic signed [31:0]      o_point_y,
    output logic signed [31:0]      o_point_z,
    output logic signed [31:0]      o_point_weight,
    output logic [4:0]              o_point_index,
    output logic                    o_last_point
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] r_state, n_state;
    logic [1:0] r_comp, n_comp;   // 0..2 coordinates, 3 weight
    logic [2:0] r_step, n_step;   // 0..4 within one sum

    logic [3:0] r_degree;
    logic [1:0] r_rule;

    logic signed [31:0] r_vtx [9];
    logic [31:0]        r_area;
    logic signed [31:0] r_res [4];

    t_seq_ctl seq_ctl;
    logic signed [31:0] bc0, bc1, bc2, weight;
    logic [4:0] pt_index;
    logic       pt_last;

    logic signed [32:0] mac_a, mac_b;
    logic               mul_en, acc_en, acc_clr;
    logic signed [31:0] mac_res;
    logic [3:0]         vtx_sel;
    logic               in_take, out_take;

    assign in_take  = i_valid && !o_stall;
    assign out_take = o_valid && !i_stall;
    assign o_stall  = r_state != ST_IDLE;
    assign o_valid  = r_state == ST_OUT;

    // config registers, to be written only while idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 4'd11;
            r_rule   <= 2'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEGREE: r_degree <= i_cfg_data;
                CFG_RULE:   r_rule   <= i_cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    // latch the triangle on accept
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_vtx[0] <= i_vertex_a_x;
            r_vtx[1] <= i_vertex_a_y;
            r_vtx[2] <= i_vertex_a_z;
            r_vtx[3] <= i_vertex_b_x;
            r_vtx[4] <= i_vertex_b_y;
            r_vtx[5] <= i_vertex_b_z;
            r_vtx[6] <= i_vertex_c_x;
            r_vtx[7] <= i_vertex_c_y;
            r_vtx[8] <= i_vertex_c_z;
            r_area   <= i_triangle_area;
        end
    end

    assign seq_ctl.start   = in_take;
    assign seq_ctl.advance = out_take && !pt_last;
    assign seq_ctl.rule    = pick_rule(r_degree, r_rule);

    tcpg_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (seq_ctl),
        .o_bc0    (bc0),
        .o_bc1    (bc1),
        .o_bc2    (bc2),
        .o_weight (weight),
        .o_index  (pt_index),
        .o_last   (pt_last)
    );

    // operand select for the shared multiplier
    // steps 0..2 multiply term 0..2, steps 1..3 accumulate, step 4 captures
    always_comb begin
        vtx_sel = 4'(r_step) * 4'd3 + 4'(r_comp);
        mac_a   = '0;
        mac_b   = '0;
        if (r_comp == 2'd3) begin
            // weight: only term 0 is non-zero
            if (r_step == 3'd0) begin
                mac_a = 33'(weight);
                mac_b = signed'({1'b0, r_area});
            end
        end else begin
            case (r_step)
                3'd0:    mac_a = 33'(bc0);
                3'd1:    mac_a = 33'(bc1);
                default: mac_a = 33'(bc2);
            endcase
            if (r_step < 3'd3) begin
                mac_b = 33'(r_vtx[vtx_sel]);
            end
        end
        mul_en  = r_state == ST_CALC && r_step < 3'd3;
        acc_en  = r_state == ST_CALC && r_step >= 3'd1 && r_step <= 3'd3;
        acc_clr = r_step == 3'd1;
    end

    tcpg_mac u_mac (
        .i_clk     (i_clk),
        .i_a       (mac_a),
        .i_b       (mac_b),
        .i_mul_en  (mul_en),
        .i_acc_en  (acc_en),
        .i_acc_clr (acc_clr),
        .o_result  (mac_res)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC && r_step == 3'd4) begin
            r_res[r_comp] <= mac_res;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_comp  = r_comp;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_CALC;
                    n_comp  = 2'd0;
                    n_step  = 3'd0;
                end
            end
            ST_CALC: begin
                if (r_step == 3'd4) begin
                    n_step = 3'd0;
                    n_comp = r_comp + 2'd1;
                    if (r_comp == 2'd3) begin
                        n_state = ST_OUT;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_OUT: begin
                if (out_take) begin
                    n_state = pt_last ? ST_IDLE : ST_CALC;
                    n_comp  = 2'd0;
                    n_step  = 3'd0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_comp  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_comp  <= n_comp;
            r_step  <= n_step;
        end
    end

    assign o_point_x      = r_res[0];
    assign o_point_y      = r_res[1];
    assign o_point_z      = r_res[2];
    assign o_point_weight = r_res[3];
    assign o_point_index  = pt_index;
    assign o_last_point   = pt_last;

    // a result is only shown while the input side is held off
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> o_stall)
        else $error("output valid while input open");
    // a new triangle always starts with computation, not output
    assert property (@(posedge i_clk) disable iff (!i_rst_n) in_take |=> !o_valid)
        else $error("output valid right after accept");
    // after a non-final point the next one is computed first
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && !o_last_point |=> !o_valid && o_point_index == $past(o_point_index) + 5'd1)
        else $error("point sequence broken");
    // the final point of a triangle returns the block to idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && o_last_point |=> !o_stall)
        else $error("not idle after last point");
endmodule
`default_nettype wire

// File: sv/tcpg_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcpg_seq
// walks the generators of a rule and expands each into its permutations
// ---------------------------------------------------------------------------
module tcpg_seq import tcpg_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_seq_ctl           i_ctl,
    output logic signed [31:0]      o_bc0,
    output logic signed [31:0]      o_bc1,
    output logic signed [31:0]      o_bc2,
    output logic signed [31:0]      o_weight,
    output logic [4:0]              o_index,
    output logic                    o_last
);
    logic [5:0] r_gen, n_gen;
    logic [2:0] r_sub, n_sub;
    logic [4:0] r_cnt, n_cnt;
    logic [4:0] r_npts, n_npts;

    logic [2:0] kind;
    logic [2:0] row;
    logic signed [31:0] c [3];
    logic [1:0] sel0, sel1, sel2;

    always_comb begin
        kind = GEN_KIND[r_gen];
        if (kind == 3'd6) begin
            row = r_sub;
        end else if (kind == 3'd3) begin
            case (r_sub)
                3'd1:    row = 3'd3;
                3'd2:    row = 3'd4;
                default: row = 3'd0;
            endcase
        end else begin
            row = 3'd0;
        end
        case (row)
            3'd1:    begin sel0 = 2'd0; sel1 = 2'd2; sel2 = 2'd1; end
            3'd2:    begin sel0 = 2'd1; sel1 = 2'd0; sel2 = 2'd2; end
            3'd3:    begin sel0 = 2'd2; sel1 = 2'd0; sel2 = 2'd1; end
            3'd4:    begin sel0 = 2'd1; sel1 = 2'd2; sel2 = 2'd0; end
            3'd5:    begin sel0 = 2'd2; sel1 = 2'd1; sel2 = 2'd0; end
            default: begin sel0 = 2'd0; sel1 = 2'd1; sel2 = 2'd2; end
        endcase
        c[0] = signed'(GEN_C1[r_gen]);
        c[1] = signed'(GEN_C2[r_gen]);
        c[2] = ONE_Q30 - c[0] - c[1];
    end

    assign o_bc0    = c[sel0];
    assign o_bc1    = c[sel1];
    assign o_bc2    = c[sel2];
    assign o_weight = signed'(GEN_W[r_gen]);
    assign o_index  = r_cnt;
    assign o_last   = (r_cnt + 5'd1) == r_npts;

    always_comb begin
        n_gen  = r_gen;
        n_sub  = r_sub;
        n_cnt  = r_cnt;
        n_npts = r_npts;
        if (i_ctl.start) begin
            n_gen  = RULE_FIRST[i_ctl.rule];
            n_sub  = 3'd0;
            n_cnt  = 5'd0;
            n_npts = RULE_POINTS[i_ctl.rule];
        end else if (i_ctl.advance) begin
            n_cnt = r_cnt + 5'd1;
            if (r_sub + 3'd1 == kind) begin
                n_gen = r_gen + 6'd1;
                n_sub = 3'd0;
            end else begin
                n_sub = r_sub + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen  <= '0;
            r_sub  <= '0;
            r_cnt  <= '0;
            r_npts <= 5'd1;
        end else begin
            r_gen  <= n_gen;
            r_sub  <= n_sub;
            r_cnt  <= n_cnt;
            r_npts <= n_npts;
        end
    end
endmodule
`default_nettype wire

// File: sv/tcpg_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcpg_mac
// shared multiply-accumulate with round-half-up and 32-bit saturation
// ---------------------------------------------------------------------------
module tcpg_mac (
    input  wire logic               i_clk,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [32:0] i_b,
    input  wire logic               i_mul_en,
    input  wire logic               i_acc_en,
    input  wire logic               i_acc_clr,
    output logic signed [31:0]      o_result
);
    logic signed [65:0] r_prod;
    logic signed [67:0] r_acc, n_acc;
    logic signed [67:0] rnd;
    logic signed [37:0] shifted;

    always_comb begin
        n_acc   = (i_acc_clr ? 68'sd0 : r_acc) + 68'(r_prod);
        rnd     = r_acc + 68'sd536870912;
        shifted = 38'(rnd >>> 30);
        if (shifted > 38'sd2147483647) begin
            o_result = 32'sh7fffffff;
        end else if (shifted < -38'sd2147483648) begin
            o_result = 32'sh80000000;
        end else begin
            o_result = 32'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= 66'(i_a * i_b);
        end
        if (i_acc_en) begin
            r_acc <= n_acc;
        end
    end
endmodule
`default_nettype wire
